// ===== src/itqe_pkg.sv =====
// ----------------------------------------------------------------------------
// itqe_pkg: shared types of the counting-tree quantile estimator
// Controller states and the command and status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package itqe_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_K_MUL,
        S_K_ADD,
        S_D_RDL,
        S_D_RDR,
        S_D_EVAL,
        S_DIV,
        S_MUL,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic up_rd;
        logic up_wr;
        logic k_mul;
        logic k_add;
        logic rd_left;
        logic rd_right;
        logic eval;
        logic div_step;
        logic mul;
        logic fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic up_root;
        logic total_zero;
        logic match;
        logic last_lvl;
        logic div_done;
        logic out_free;
    } t_sts;

    localparam logic [16:0] Q_ONE  = 17'd65536;
    localparam logic [16:0] Q_HALF = 17'd32768;

endpackage

`default_nettype wire

// ===== src/itqe_if.sv =====
// ----------------------------------------------------------------------------
// itqe_if: stream channels of the counting-tree quantile estimator
// Input word (op, value) and result word (quantile, empty_res).
// ----------------------------------------------------------------------------
`default_nettype none

interface itqe_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [17:0] value;
    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

interface itqe_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] quantile;
    logic        empty_res;
    modport source (output valid, quantile, empty_res, input ready);
    modport sink   (input valid, quantile, empty_res, output ready);
endinterface

`default_nettype wire

// ===== src/itqe_ram.sv =====
// ----------------------------------------------------------------------------
// itqe_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/itqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// itqe_ctrl: sequencer of the quantile estimator
// Clear sweep, path update, threshold, descent, weight division, result.
// ----------------------------------------------------------------------------
`default_nettype none

module itqe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire itqe_pkg::t_sts i_sts,
    output itqe_pkg::t_cmd     o_cmd
);

    itqe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itqe_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            itqe_pkg::S_CLEAR:  if (i_sts.clr_last) n_state = itqe_pkg::S_IDLE;
            itqe_pkg::S_IDLE:   if (i_in_valid) n_state = itqe_pkg::S_UP_RD;
            itqe_pkg::S_UP_RD:  n_state = itqe_pkg::S_UP_WR;
            itqe_pkg::S_UP_WR:  n_state = i_sts.up_root ? itqe_pkg::S_K_MUL
                                                        : itqe_pkg::S_UP_RD;
            itqe_pkg::S_K_MUL:  n_state = itqe_pkg::S_K_ADD;
            itqe_pkg::S_K_ADD:  n_state = i_sts.total_zero ? itqe_pkg::S_DONE
                                                           : itqe_pkg::S_D_RDL;
            itqe_pkg::S_D_RDL:  n_state = itqe_pkg::S_D_RDR;
            itqe_pkg::S_D_RDR:  n_state = itqe_pkg::S_D_EVAL;
            itqe_pkg::S_D_EVAL: begin
                if (i_sts.match) begin
                    n_state = itqe_pkg::S_DIV;
                end else if (i_sts.last_lvl) begin
                    n_state = itqe_pkg::S_FIN;
                end else begin
                    n_state = itqe_pkg::S_D_RDL;
                end
            end
            itqe_pkg::S_DIV:    if (i_sts.div_done) n_state = itqe_pkg::S_MUL;
            itqe_pkg::S_MUL:    n_state = itqe_pkg::S_FIN;
            itqe_pkg::S_FIN:    n_state = itqe_pkg::S_DONE;
            itqe_pkg::S_DONE:   if (i_sts.out_free) n_state = itqe_pkg::S_IDLE;
            default:            n_state = itqe_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            itqe_pkg::S_CLEAR:  o_cmd.clr_wr = 1'b1;
            itqe_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            itqe_pkg::S_UP_RD:  o_cmd.up_rd    = 1'b1;
            itqe_pkg::S_UP_WR:  o_cmd.up_wr    = 1'b1;
            itqe_pkg::S_K_MUL:  o_cmd.k_mul    = 1'b1;
            itqe_pkg::S_K_ADD:  o_cmd.k_add    = 1'b1;
            itqe_pkg::S_D_RDL:  o_cmd.rd_left  = 1'b1;
            itqe_pkg::S_D_RDR:  o_cmd.rd_right = 1'b1;
            itqe_pkg::S_D_EVAL: o_cmd.eval     = 1'b1;
            itqe_pkg::S_DIV:    o_cmd.div_step = !i_sts.div_done;
            itqe_pkg::S_MUL:    o_cmd.mul      = 1'b1;
            itqe_pkg::S_FIN:    o_cmd.fin      = 1'b1;
            itqe_pkg::S_DONE:   o_cmd.out_load = i_sts.out_free;
            default:            o_cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/itqe_dp.sv =====
// ----------------------------------------------------------------------------
// itqe_dp: datapath of the quantile estimator
// Node count RAM, path update, descent registers, weight divider, result.
// ----------------------------------------------------------------------------
`default_nettype none

module itqe_dp #(
    parameter int TREE_LEVELS = 10,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire itqe_pkg::t_cmd     i_cmd,
    output itqe_pkg::t_sts          o_sts,
    input  wire logic               i_op,
    input  wire logic signed [17:0] i_value,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [16:0]        i_cfg_wr_data,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [16:0]             o_quantile,
    output logic                    o_empty_res
);

    localparam int L      = TREE_LEVELS;
    localparam int CW     = COUNT_WIDTH;
    localparam int AW     = L + 1;
    localparam int NODES  = 1 << AW;
    localparam int LEAVES = 1 << L;
    localparam int SHIFT  = 16 - L;
    localparam int TW     = CW + 16;
    localparam int DW     = $clog2(L);

    // Configuration
    logic [16:0] r_qlev;
    logic [16:0] q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlev <= itqe_pkg::Q_HALF;
        end else if (i_cfg_wr_en) begin
            r_qlev <= i_cfg_wr_data;
        end
    end

    assign q = (r_qlev > itqe_pkg::Q_ONE) ? itqe_pkg::Q_ONE : r_qlev;

    // Leaf of the incoming value
    logic [17:0] mag;
    logic [18:0] bin_raw;
    logic [18:0] bin_c;
    logic [AW-1:0] leaf_node;

    always_comb begin
        mag     = i_value[17] ? 18'(-i_value) : 18'(i_value);
        bin_raw = (19'(mag) + 19'((1 << SHIFT) - 1)) >> SHIFT;
        if (bin_raw == 19'd0) begin
            bin_c = 19'd1;
        end else if (bin_raw > 19'(LEAVES)) begin
            bin_c = 19'(LEAVES);
        end else begin
            bin_c = bin_raw;
        end
        leaf_node = {1'b1, L'(bin_c - 19'd1)};
    end

    // Registers
    logic [AW-1:0]  r_caddr;
    logic           r_op;
    logic [AW-1:0]  r_node;
    logic [CW-1:0]  r_total;
    logic [CW+16:0] r_p1;
    logic [33:0]    r_p2;
    logic [CW-1:0]  r_k;
    logic [L-1:0]   r_i;
    logic [CW-1:0]  r_ci;
    logic [CW-1:0]  r_cl;
    logic [34:0]    r_l;
    logic [5:0]     r_sh;
    logic [DW-1:0]  r_d;
    logic           r_leaf;
    logic [CW:0]    r_s;
    logic [CW+1:0]  r_rem;
    logic [16:0]    r_w;
    logic [4:0]     r_dcnt;
    logic           r_ddone;
    logic [33:0]    r_prod;
    logic [16:0]    r_res;
    logic           r_res_empty;
    logic           r_ovalid;

    // RAM hookup
    logic [CW-1:0] rd_data;
    logic [CW-1:0] upd;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_comb begin
        if (!r_op) begin
            upd = (rd_data != {CW{1'b1}}) ? rd_data + CW'(1) : rd_data;
        end else begin
            upd = (rd_data != '0) ? rd_data - CW'(1) : rd_data;
        end
        wr_en   = i_cmd.clr_wr | i_cmd.up_wr;
        wr_addr = i_cmd.clr_wr ? r_caddr : r_node;
        wr_data = i_cmd.clr_wr ? '0 : upd;
        rd_en   = i_cmd.up_rd | i_cmd.rd_left | i_cmd.rd_right;
        if (i_cmd.up_rd) begin
            rd_addr = r_node;
        end else if (i_cmd.rd_left) begin
            rd_addr = {r_i, 1'b0};
        end else begin
            rd_addr = {r_i, 1'b1};
        end
    end

    itqe_ram #(
        .WIDTH (CW),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Arithmetic helpers
    logic [TW-1:0] tot_ext;
    logic [CW+1:0] rem2;
    logic [35:0]   v_leaf;
    logic [51:0]   quarter;
    logic [51:0]   pb;
    logic [51:0]   mix;
    logic [16:0]   fin_res;

    always_comb begin
        tot_ext = TW'(r_total);
        rem2    = {r_rem[CW:0], 1'b0};
        v_leaf  = 36'(r_l) + (36'(q) << (r_sh - 6'd16));
        quarter = 52'(1) << (r_sh - 6'd2);
        pb      = 52'(r_l) + quarter + (quarter << 1) + (52'(q) << (r_sh - 6'd18));
        mix     = (pb << 16) - (52'(r_prod) << (r_sh - 6'd18));
        if (r_leaf) begin
            fin_res = 17'((v_leaf + (36'(1) << 17)) >> 18);
        end else begin
            fin_res = 17'((mix + (52'(1) << 33)) >> 34);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_caddr <= r_caddr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_node <= leaf_node;
        end
        if (i_cmd.up_wr) begin
            if (r_node == AW'(1)) begin
                r_total <= upd;
            end
            r_node <= r_node >> 1;
        end
        if (i_cmd.k_mul) begin
            r_p1 <= (CW+17)'(tot_ext[TW-1:16]) * (CW+17)'(q);
            r_p2 <= 34'(tot_ext[15:0]) * 34'(q) + 34'(65535);
        end
        if (i_cmd.k_add) begin
            r_k         <= CW'(r_p1 + (CW+17)'(r_p2 >> 16));
            r_i         <= L'(1);
            r_ci        <= r_total;
            r_l         <= '0;
            r_sh        <= 6'd34;
            r_d         <= '0;
            r_res       <= '0;
            r_res_empty <= 1'b1;
        end
        if (i_cmd.rd_right) begin
            r_cl <= rd_data;
        end
        if (i_cmd.eval) begin
            if (r_ci == r_k) begin
                r_leaf <= 1'b0;
                r_s    <= (CW+1)'(r_cl) + (CW+1)'(rd_data);
                r_rem  <= (CW+2)'(r_cl);
                r_dcnt <= '0;
                if (r_cl == '0 && rd_data == '0) begin
                    r_w     <= itqe_pkg::Q_HALF;
                    r_ddone <= 1'b1;
                end else if (rd_data == '0) begin
                    r_w     <= itqe_pkg::Q_ONE;
                    r_ddone <= 1'b1;
                end else begin
                    r_w     <= '0;
                    r_ddone <= 1'b0;
                end
            end else begin
                r_leaf <= 1'b1;
                r_sh   <= r_sh - 6'd1;
                r_d    <= r_d + DW'(1);
                if (r_cl >= r_k) begin
                    r_i  <= {r_i[L-2:0], 1'b0};
                    r_ci <= r_cl;
                end else begin
                    r_k  <= r_k - r_cl;
                    r_i  <= {r_i[L-2:0], 1'b1};
                    r_ci <= rd_data;
                    r_l  <= r_l + (35'(1) << (r_sh - 6'd1));
                end
            end
        end
        if (i_cmd.div_step) begin
            if (r_dcnt != 5'd16) begin
                // one quotient bit per cycle
                if (rem2 >= (CW+2)'(r_s)) begin
                    r_rem <= rem2 - (CW+2)'(r_s);
                    r_w   <= {r_w[15:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_w   <= {r_w[15:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 5'd1;
            end else begin
                // round half up
                if (rem2 >= (CW+2)'(r_s)) begin
                    r_w <= r_w + 17'd1;
                end
                r_ddone <= 1'b1;
            end
        end
        if (i_cmd.mul) begin
            // weight times the gap between the two child points, in units of 2^(sh-18)
            r_prod <= 34'(r_w) * (34'(3) * 34'(itqe_pkg::Q_ONE) - 34'(q));
        end
        if (i_cmd.fin) begin
            r_res       <= fin_res;
            r_res_empty <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_quantile  <= r_res;
            o_empty_res <= r_res_empty;
        end
    end

    assign o_out_valid = r_ovalid;

    always_comb begin
        o_sts.clr_last   = &r_caddr;
        o_sts.up_root    = (r_node == AW'(1));
        o_sts.total_zero = (r_total == '0);
        o_sts.match      = (r_ci == r_k);
        o_sts.last_lvl   = (r_d == DW'(L - 1));
        o_sts.div_done   = r_ddone;
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

endmodule

`default_nettype wire

// ===== src/interval_tree_quantile_estimator.sv =====
// ----------------------------------------------------------------------------
// interval_tree_quantile_estimator: approximate quantile on a counting tree
// Binned magnitudes in a binary tree of subtree counts; each word updates
// the tree and returns the requested quantile.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  (valid/ready): one word = op (0 add, 1 remove) and a signed Q.16
//         value. A word is taken at a clock edge with valid and ready high.
//   o_out (valid/ready): one result word per input word, the Q1.16 quantile
//         and empty_res. The result sits in an output register until taken.
//   i_cfg_wr_en / i_cfg_wr_data: quantile level, Q1.16, written while idle.
// Sequence, with L = TREE_LEVELS:
//   update of the leaf-to-root path: one RAM read and one write per node,
//   L+1 nodes, over the single node-count RAM.
//   threshold: a multiply and an add; descent: read left, read right and
//   evaluate per level, up to L levels.
//   leaf answer: a final step and the output load; an exact match instead
//   runs the bit-serial weight divider, a multiply and the final step.
//   An empty tree skips the descent and goes straight to the output load.
// Reset: the node RAM is swept to zero, one node per cycle, all 2^(L+1) nodes
//   with ready low; the level returns to one half.
// Stall: a new word is accepted while the last result waits; its own result
//   then holds in the datapath until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_tree_quantile_estimator #(
    parameter int TREE_LEVELS = 10,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    itqe_in_if.sink          i_in,
    itqe_out_if.source       o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [16:0] i_cfg_wr_data
);

    itqe_pkg::t_cmd cmd;
    itqe_pkg::t_sts sts;
    logic           in_ready;

    // sequencer
    itqe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // counts, descent and arithmetic
    itqe_dp #(
        .TREE_LEVELS (TREE_LEVELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_in.op),
        .i_value       (i_in.value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_quantile    (o_out.quantile),
        .o_empty_res   (o_out.empty_res)
    );

    assign i_in.ready = in_ready;

    // an empty tree always reports zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.empty_res |-> o_out.quantile == 17'd0)
        else $error("empty result with nonzero quantile");

    // quantile never exceeds one
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.quantile <= 17'd65536)
        else $error("quantile above one");

    // no word is taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !i_in.ready)
        else $error("ready during clear");

    // an accepted word starts the path update next cycle
    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> cmd.up_rd)
        else $error("update did not start");

endmodule

`default_nettype wire

// ===== verif/itqe_sb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itqe_sb: quantile prediction and result check for the tree estimator
// Keeps its own count tree, predicts one quantile word per accepted input
// word and compares result words in order against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class itqe_quantile_sb;
    localparam int LVL   = 10;
    localparam int NODES = 1 << (LVL + 1);
    localparam int LEAVES = 1 << LVL;
    localparam longint unsigned CMAX = (64'd1 << 32) - 1;

    longint unsigned cnt[NODES];
    longint unsigned level_q;
    bit [17:0] pending_q[$];
    int mismatches;

    function new();
        foreach (cnt[n]) cnt[n] = 0;
        level_q = 32768;
        mismatches = 0;
    endfunction

    function void set_level(bit [16:0] v);
        level_q = v;
    endfunction

    function longint unsigned split_weight(longint unsigned a, longint unsigned s);
        longint unsigned rem, w;
        if (s == 0) return 32768;
        if (a >= s) return 65536;
        rem = a;
        w = 0;
        for (int b = 0; b < 16; b++) begin
            rem = rem << 1;
            w = w << 1;
            if (rem >= s) begin
                rem -= s;
                w |= 1;
            end
        end
        if ((rem << 1) >= s) w += 1;
        return w;
    endfunction

    function longint unsigned descend();
        longint unsigned q, k, l, u, cl, cr, lu, rl, pa, pb, lw, r, v;
        int i, j;
        q = (level_q > 65536) ? 65536 : level_q;
        k = (cnt[1] >> 16) * q + (((cnt[1] & 16'hFFFF) * q + 65535) >> 16);
        l = 0;
        u = 64'd1 << 34;
        i = 1;
        for (int d = 0; d < LVL; d++) begin
            j = (i << 1) & (NODES - 1);
            cl = cnt[j];
            if (cnt[i] == k) begin
                cr = cnt[(j + 1) & (NODES - 1)];
                lu = (l + u) >> 1;
                rl = (u + lu) >> 1;
                pa = l + ((q * (lu - l)) >> 16);
                pb = rl + ((q * (u - rl)) >> 16);
                lw = split_weight(cl, cl + cr);
                r = lw * pa + (65536 - lw) * pb;
                return (r + (64'd1 << 33)) >> 34;
            end else if (cl >= k) begin
                i = j;
                u = (l + u) >> 1;
            end else begin
                k -= cl;
                i = j + 1;
                l = (l + u) >> 1;
            end
        end
        v = l + ((q * (u - l)) >> 16);
        return (v + (64'd1 << 17)) >> 18;
    endfunction

    // Update the path for one accepted word and queue its expected result.
    function void note_word(bit op, bit [17:0] raw);
        longint unsigned mag, bin;
        int node;
        bit [16:0] qv;
        mag = raw[17] ? ((19'h40000 - raw) & 18'h3FFFF) : raw;
        bin = (mag + 63) >> 6;
        if (bin < 1) bin = 1;
        if (bin > LEAVES) bin = LEAVES;
        node = (bin + LEAVES - 1) & (NODES - 1);
        while (node != 0) begin
            if (!op) begin
                if (cnt[node] < CMAX) cnt[node]++;
            end else if (cnt[node] > 0) begin
                cnt[node]--;
            end
            node = node >> 1;
        end
        if (cnt[1] == 0) pending_q.push_back({17'd0, 1'b1});
        else begin
            qv = 17'(descend());
            pending_q.push_back({qv, 1'b0});
        end
    endfunction

    function void check_word(bit [16:0] qv, bit e);
        bit [17:0] want;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: quantile=%0d empty=%0b", qv, e);
            return;
        end
        want = pending_q.pop_front();
        if (want != {qv, e}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected quantile=%0d empty=%0b, got %0d %0b",
                         want[17:1], want[0], qv, e);
        end
    endfunction
endclass

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the counting-tree quantile estimator
// Drives add/remove words through several quantile levels with random gaps
// and output stalls; every result word is checked against a prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [16:0] cfg_wr_data = '0;
    int          stall_cycles = 0;
    bit          timed_out = 1'b0;

    itqe_in_if  in_ch();
    itqe_out_if out_ch();

    itqe_quantile_sb sb = new();

    interval_tree_quantile_estimator #(.TREE_LEVELS(10), .COUNT_WIDTH(32)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch.sink),
        .o_out        (out_ch.source),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
    end

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Sink side: toggle ready at random, check every accepted result word.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.quantile, out_ch.empty_res);
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_cycles <= pick_gap();
        end
    end

    // Watchdog: count cycles without any accepted word on either channel.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one word, hold it until accepted, then drop valid for a random gap, if any.
    task automatic send_word(bit op, bit [17:0] raw);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(op, raw);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until all predictions are consumed, drain, then write the level.
    task automatic write_level(bit [16:0] lvl);
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.set_level(lvl);
        @(posedge i_clk);
    endtask

    // Values near bin edges, zero, full scale and random magnitudes.
    function automatic bit [17:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 18'd0;
        if (r == 1) return $urandom_range(0, 1) ? 18'd65536 : -18'sd65536;
        if (r == 2) return 18'($urandom_range(65537, 131071));
        if (r == 3) return -18'($urandom_range(65537, 131072));
        if (r == 4) return 18'($urandom_range(0, 15) * 64 + $urandom_range(0, 1));
        return 18'($urandom());
    endfunction

    initial begin
        bit [16:0] levels[6];
        bit [17:0] dir[$];
        int live;
        levels = '{17'd0, 17'd65536, 17'd131071, 17'd16384, 17'd49151, 17'd32768};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty remove, extremes, zero, overrange, duplicate values.
        dir = '{18'd0, 18'd65536, 18'h20000, 18'h1FFFF, 18'd1, 18'h3FFFF,
                18'd64, 18'd65, 18'd32768, 18'd32768, 18'h38000};
        send_word(1'b1, 18'd0);
        foreach (dir[n]) send_word(1'b0, dir[n]);
        send_word(1'b1, 18'd64);
        send_word(1'b1, 18'd64);
        write_level(17'd65536);
        send_word(1'b0, 18'd100);
        send_word(1'b1, 18'd100);
        write_level(17'd0);
        send_word(1'b0, 18'd40000);
        send_word(1'b0, 18'd40000);
        live = dir.size();

        // Random phases: mostly adds at first, balanced later, each level.
        foreach (levels[p]) begin
            write_level(levels[p]);
            repeat (190) begin
                bit op;
                op = (live > 0 && $urandom_range(0, 99) < (p < 2 ? 30 : 50));
                live += op ? -1 : 1;
                send_word(op, pick_value());
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
